// ----- hw/rtl/cslp_pkg.sv -----
// Package for the CPU stat line parser: widths, character codes, status codes,
// the snapshot type passed from the parser core to the finish stage and the shared field-close function.
// No dependencies.
package cslp_pkg;

    // Counter width; the counter limit is 2^COUNTER_BITS - 1 (legal range 16..63)
    localparam int COUNTER_BITS = 63;
    localparam int OUT_W        = 63;
    // Width of a field times ten plus a digit before the limit check
    localparam int PROD_W       = COUNTER_BITS + 4;

    typedef logic [COUNTER_BITS-1:0] cnt_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FORMAT   = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // Line prefix "cpu "
    localparam logic [2:0] PREFIX_LEN = 3'd4;
    localparam logic [7:0] LEAD_TEXT [4] = '{8'h63, 8'h70, 8'h75, 8'h20};

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Field numbering: fields 3 and 4 are idle and iowait
    localparam logic [2:0] FC_IDLE   = 3'd3;
    localparam logic [2:0] FC_IOWAIT = 3'd4;
    localparam logic [2:0] FC_MAX    = 3'd5;
    localparam logic [2:0] FC_NEEDED = 3'd4;

    // Parser state after the last byte, handed to the finish stage
    typedef struct packed {
        logic       stopped;
        status_t    err;
        logic       in_number;
        cnt_t       number;
        cnt_t       total;
        cnt_t       idle;
        logic [2:0] field_count;
        logic       prefix_done;
    } snap_t;

    typedef struct packed {
        logic       ovf;
        cnt_t       total;
        cnt_t       idle;
        logic [2:0] field_count;
    } close_t;

    // Close a finished field: add into total (and idle for fields 3 and 4).
    // The limit is all ones, so overflow is the carry out of the add.
    function automatic close_t close_field(cnt_t total, cnt_t idle, cnt_t number,
                                           logic [2:0] field_count);
        logic [COUNTER_BITS:0] sum;
        close_t                r;
        sum           = {1'b0, total} + {1'b0, number};
        r.ovf         = sum[COUNTER_BITS];
        r.total       = sum[COUNTER_BITS-1:0];
        r.idle        = (field_count == FC_IDLE || field_count == FC_IOWAIT)
                        ? idle + number : idle;
        r.field_count = (field_count < FC_MAX) ? field_count + 3'd1 : field_count;
        return r;
    endfunction

endpackage

// ----- hw/rtl/cslp_byte_if.sv -----
// Byte channel of the CPU stat line parser: valid/ready plus one byte and a last marker.
// Depends on nothing.
interface cslp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// ----- hw/rtl/cslp_stat_if.sv -----
// Result channel of the CPU stat line parser: valid/ready plus status and jiffy counts.
// Depends on nothing.
interface cslp_stat_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [62:0] idle_jiffies;
    logic [62:0] total_jiffies;

    modport source (output valid, output status, output idle_jiffies,
                    output total_jiffies, input ready);
    modport sink   (input valid, input status, input idle_jiffies,
                    input total_jiffies, output ready);
endinterface

// ----- hw/rtl/cslp_core.sv -----
// Parser core: input register, per-byte prefix/field parsing and the running state.
// Depends on cslp_pkg and cslp_byte_if.
module cslp_core (
    input  logic            clk,
    input  logic            rst_n,
    cslp_byte_if.sink       bytes,
    output logic            snap_valid,
    output cslp_pkg::snap_t snap,
    input  logic            snap_ready
);
    import cslp_pkg::*;

    // Input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       s1_go;

    // Parser state
    logic [2:0] prefix_reg;
    logic       stopped_reg;
    status_t    err_reg;
    logic       in_number_reg;
    cnt_t       number_reg;
    cnt_t       total_reg;
    cnt_t       idle_reg;
    logic [2:0] fc_reg;

    // Next state for the byte held in the input register
    logic [2:0]  prefix_next;
    logic        stopped_next;
    status_t     err_next;
    logic        in_number_next;
    cnt_t        number_next;
    cnt_t        total_next;
    cnt_t        idle_next;
    logic [2:0]  fc_next;

    logic        digit_hit;
    logic [3:0]  digit;
    cnt_t        number_base;
    logic [PROD_W-1:0] prod;
    close_t      cl;

    // A last byte needs room in the finish stage; other bytes always go
    assign s1_go       = s1_valid_reg && (!s1_last_reg || snap_ready);
    assign bytes.ready = !s1_valid_reg || s1_go;
    assign snap_valid  = s1_valid_reg && s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (bytes.ready)
        begin
            s1_valid_reg <= bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            s1_byte_reg <= bytes.data_byte;
            s1_last_reg <= bytes.last;
        end
    end

    // Digit step: number * 10 + digit, overflow when any bit above the counter is set
    assign digit_hit   = (s1_byte_reg >= CHAR_ZERO) && (s1_byte_reg <= CHAR_NINE);
    assign digit       = s1_byte_reg[3:0];
    assign number_base = in_number_reg ? number_reg : '0;
    assign prod        = (PROD_W'(number_base) << 3) + (PROD_W'(number_base) << 1)
                         + PROD_W'(digit);
    assign cl          = close_field(total_reg, idle_reg, number_reg, fc_reg);

    // Per-byte parse
    always_comb
    begin
        prefix_next    = prefix_reg;
        stopped_next   = stopped_reg;
        err_next       = err_reg;
        in_number_next = in_number_reg;
        number_next    = number_reg;
        total_next     = total_reg;
        idle_next      = idle_reg;
        fc_next        = fc_reg;
        if (!stopped_reg)
        begin
            if (prefix_reg != PREFIX_LEN)
            begin
                if (s1_byte_reg == LEAD_TEXT[prefix_reg[1:0]])
                begin
                    prefix_next = prefix_reg + 3'd1;
                end
                else
                begin
                    err_next     = ST_FORMAT;
                    stopped_next = 1'b1;
                end
            end
            else if (digit_hit)
            begin
                in_number_next = 1'b1;
                if (prod[PROD_W-1:COUNTER_BITS] != '0)
                begin
                    number_next  = number_base;
                    err_next     = ST_OVERFLOW;
                    stopped_next = 1'b1;
                end
                else
                begin
                    number_next = prod[COUNTER_BITS-1:0];
                end
            end
            else
            begin
                // Separator or terminator closes an open field first
                if (in_number_reg)
                begin
                    in_number_next = 1'b0;
                    number_next    = '0;
                    if (cl.ovf)
                    begin
                        err_next     = ST_OVERFLOW;
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        total_next = cl.total;
                        idle_next  = cl.idle;
                        fc_next    = cl.field_count;
                    end
                end
                if (s1_byte_reg != CHAR_SPACE && s1_byte_reg != CHAR_TAB)
                begin
                    stopped_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        snap.stopped     = stopped_next;
        snap.err         = err_next;
        snap.in_number   = in_number_next;
        snap.number      = number_next;
        snap.total       = total_next;
        snap.idle        = idle_next;
        snap.field_count = fc_next;
        snap.prefix_done = (prefix_next == PREFIX_LEN);
    end

    // State update; a last byte returns the parser to its reset state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg    <= '0;
            stopped_reg   <= 1'b0;
            err_reg       <= ST_OK;
            in_number_reg <= 1'b0;
            number_reg    <= '0;
            total_reg     <= '0;
            idle_reg      <= '0;
            fc_reg        <= '0;
        end
        else if (s1_go)
        begin
            if (s1_last_reg)
            begin
                prefix_reg    <= '0;
                stopped_reg   <= 1'b0;
                err_reg       <= ST_OK;
                in_number_reg <= 1'b0;
                number_reg    <= '0;
                total_reg     <= '0;
                idle_reg      <= '0;
                fc_reg        <= '0;
            end
            else
            begin
                prefix_reg    <= prefix_next;
                stopped_reg   <= stopped_next;
                err_reg       <= err_next;
                in_number_reg <= in_number_next;
                number_reg    <= number_next;
                total_reg     <= total_next;
                idle_reg      <= idle_next;
                fc_reg        <= fc_next;
            end
        end
    end

    // An error always stops parsing
    assert property (@(posedge clk) disable iff (!rst_n)
        !stopped_reg |-> err_reg == ST_OK)
        else $error("cslp_core: error set while still parsing");

    // A consumed last byte leaves the parser in its reset state
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s1_last_reg |=> prefix_reg == '0 && !stopped_reg && fc_reg == '0
                                 && total_reg == '0)
        else $error("cslp_core: state not cleared after last byte");

    // Field count saturates and idle never exceeds total
    assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= FC_MAX && idle_reg <= total_reg)
        else $error("cslp_core: field count or idle sum out of range");

endmodule

// ----- hw/rtl/cslp_finish.sv -----
// Finish stage: snapshot register, closing of a field open at the last byte,
// final format check and the result register. Depends on cslp_pkg and cslp_stat_if.
module cslp_finish (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            snap_valid,
    input  cslp_pkg::snap_t snap,
    output logic            snap_ready,
    cslp_stat_if.source     result
);
    import cslp_pkg::*;

    logic    fin_valid_reg;
    snap_t   fin_reg;
    logic    fin_go;

    logic    out_valid_reg;
    status_t status_reg;
    cnt_t    idle_out_reg;
    cnt_t    total_out_reg;

    close_t     cl;
    status_t    err_fin;
    cnt_t       total_fin;
    cnt_t       idle_fin;
    logic [2:0] fc_fin;

    assign fin_go     = fin_valid_reg && (!out_valid_reg || result.ready);
    assign snap_ready = !fin_valid_reg || fin_go;

    // Snapshot register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (snap_ready)
        begin
            fin_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_ready && snap_valid)
        begin
            fin_reg <= snap;
        end
    end

    // Close a field still open at the last byte, then check prefix and field count
    assign cl = close_field(fin_reg.total, fin_reg.idle, fin_reg.number,
                            fin_reg.field_count);

    always_comb
    begin
        err_fin   = fin_reg.err;
        total_fin = fin_reg.total;
        idle_fin  = fin_reg.idle;
        fc_fin    = fin_reg.field_count;
        if (!fin_reg.stopped && fin_reg.in_number)
        begin
            if (cl.ovf)
            begin
                err_fin = ST_OVERFLOW;
            end
            else
            begin
                total_fin = cl.total;
                idle_fin  = cl.idle;
                fc_fin    = cl.field_count;
            end
        end
        if (err_fin == ST_OK && (!fin_reg.prefix_done || fc_fin < FC_NEEDED))
        begin
            err_fin = ST_FORMAT;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            status_reg    <= err_fin;
            idle_out_reg  <= (err_fin == ST_OK) ? idle_fin : '0;
            total_out_reg <= (err_fin == ST_OK) ? total_fin : '0;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = status_reg;
    assign result.idle_jiffies  = OUT_W'(idle_out_reg);
    assign result.total_jiffies = OUT_W'(total_out_reg);

    // Failed parses report zero counts
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |-> idle_out_reg == '0 && total_out_reg == '0)
        else $error("cslp_finish: nonzero counts on error");

    // A waiting snapshot is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg && !fin_go |=> fin_valid_reg)
        else $error("cslp_finish: snapshot lost while stalled");

    // Successful results keep idle within total
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_OK |-> idle_out_reg <= total_out_reg)
        else $error("cslp_finish: idle exceeds total");

endmodule

// ----- hw/rtl/cpu_stat_line_parser_unit.sv -----
// CPU stat line parser, top level.
// Depends on cslp_pkg, cslp_byte_if, cslp_stat_if, cslp_core and cslp_finish.
//
// Usage:
//   bytes  : one text byte per transaction, last marks the end of the buffer.
//   result : one transaction per buffer, sent after its last byte, carrying
//            status (0 ok, 1 format, 2 overflow), idle and total jiffies.
// Throughput: one byte per cycle while the byte channel is not stalled. Each byte
//   is parsed by one multiply-by-ten add and compare between the input register
//   and the parser state, so unstalled bytes follow each other on consecutive cycles.
// Result path: after the last byte is accepted, it passes the input register,
//   snapshot register and result register before the result is valid.
// Stall: bytes keep flowing while a result waits; only a last byte needs a
//   free snapshot register, so the byte channel stalls when two more
//   buffers have ended behind a result that is not taken.
// Reset: asynchronous, active low; clears the parser state and all valid
//   flags. After each last byte the parser returns to the same state.
module cpu_stat_line_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    cslp_byte_if.sink   bytes,
    cslp_stat_if.source result
);
    import cslp_pkg::*;

    logic  snap_valid;
    logic  snap_ready;
    snap_t snap;

    cslp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready)
    );

    cslp_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready),
        .result     (result)
    );

endmodule
